@@ rtl/core/maxwell_cleaning_normal_flux_macros.svh @@
// Assertion macros shared by the Maxwell cleaning normal flux modules.
`ifndef MAXWELL_CLEANING_NORMAL_FLUX_MACROS_SVH
`define MAXWELL_CLEANING_NORMAL_FLUX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCNF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mcnf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mcnf: next-cycle check failed");

`endif

@@ rtl/core/mcnf_pkg.sv @@
// Types and constants shared by the Maxwell cleaning normal flux modules.
`timescale 1ns / 1ps
package mcnf_pkg;

	localparam int unsigned VAL_W   = 32;  // Q16.16 field values and fluxes
	localparam int unsigned NRM_W   = 16;  // Q1.14 normal components
	localparam int unsigned COEF_W  = 31;  // unsigned Q15.16 coefficients
	localparam int unsigned IDX_W   = 2;   // configuration register index
	localparam int unsigned FRAC    = 16;  // fraction bits of Q16.16
	localparam int unsigned NFRAC   = 14;  // fraction bits of Q1.14
	localparam int unsigned PROD_W  = 63;  // coefficient times value
	localparam int unsigned SCL_W   = 48;  // scaled value after rounding
	localparam int unsigned TERM_W  = 63;  // scaled value times normal
	localparam int unsigned ACC_W   = 64;  // sum of three terms

	localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(65536);
	localparam logic [COEF_W-1:0] COEF_MAX   = '1;

	// Flux component slots.
	localparam int unsigned NUM_FLUX = 8;
	localparam int unsigned NUM_DIFF = 6;  // the curl rows subtract their last term
	localparam int unsigned F_MAG_X  = 0;
	localparam int unsigned F_MAG_Y  = 1;
	localparam int unsigned F_MAG_Z  = 2;
	localparam int unsigned F_ELEC_X = 3;
	localparam int unsigned F_ELEC_Y = 4;
	localparam int unsigned F_ELEC_Z = 5;
	localparam int unsigned F_PSI    = 6;
	localparam int unsigned F_PHI    = 7;

	typedef enum logic [IDX_W-1:0] {
		REG_LIGHT_SPEED = 2'd0,
		REG_E_CLEANING  = 2'd1,
		REG_B_CLEANING  = 2'd2
	} cfg_reg_t;

	typedef logic        [COEF_W-1:0] coef_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [NRM_W-1:0]  nrm_t;
	typedef logic signed [SCL_W-1:0]  scl_t;

	typedef struct packed {
		coef_t c2;   // c squared
		coef_t g2;   // gamma squared
		coef_t cx;   // c squared chi squared
		logic  sat;  // some coefficient was clipped
	} coef_set_t;

	typedef struct packed {
		val_t magnetic_x;
		val_t magnetic_y;
		val_t magnetic_z;
		val_t electric_x;
		val_t electric_y;
		val_t electric_z;
		val_t psi_potential;
		val_t phi_potential;
		nrm_t normal_x;
		nrm_t normal_y;
		nrm_t normal_z;
	} face_t;

	typedef struct packed {
		scl_t p;    // gamma^2 psi
		scl_t q;    // c^2 chi^2 phi
		scl_t sbx;  // c^2 B
		scl_t sby;
		scl_t sbz;
		scl_t ex;   // E, sign extended
		scl_t ey;
		scl_t ez;
		nrm_t nx;
		nrm_t ny;
		nrm_t nz;
		logic csat;
	} scaled_t;

	typedef struct packed {
		val_t flux_mag_x;
		val_t flux_mag_y;
		val_t flux_mag_z;
		val_t flux_elec_x;
		val_t flux_elec_y;
		val_t flux_elec_z;
		val_t flux_psi;
		val_t flux_phi;
		logic saturated;
	} result_t;

endpackage

@@ rtl/core/mcnf_if.sv @@
// Channel interfaces of the Maxwell cleaning normal flux block.
`timescale 1ns / 1ps

interface mcnf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mcnf_pkg::IDX_W-1:0]     index;
	logic [mcnf_pkg::COEF_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface mcnf_face_if;
	logic           valid;
	logic           ready;
	mcnf_pkg::val_t magnetic_x;
	mcnf_pkg::val_t magnetic_y;
	mcnf_pkg::val_t magnetic_z;
	mcnf_pkg::val_t electric_x;
	mcnf_pkg::val_t electric_y;
	mcnf_pkg::val_t electric_z;
	mcnf_pkg::val_t psi_potential;
	mcnf_pkg::val_t phi_potential;
	mcnf_pkg::nrm_t normal_x;
	mcnf_pkg::nrm_t normal_y;
	mcnf_pkg::nrm_t normal_z;
	modport source (output valid, output magnetic_x, output magnetic_y, output magnetic_z,
		output electric_x, output electric_y, output electric_z, output psi_potential,
		output phi_potential, output normal_x, output normal_y, output normal_z,
		input ready);
	modport sink (input valid, input magnetic_x, input magnetic_y, input magnetic_z,
		input electric_x, input electric_y, input electric_z, input psi_potential,
		input phi_potential, input normal_x, input normal_y, input normal_z,
		output ready);
endinterface

interface mcnf_flux_if;
	logic           valid;
	logic           ready;
	mcnf_pkg::val_t flux_mag_x;
	mcnf_pkg::val_t flux_mag_y;
	mcnf_pkg::val_t flux_mag_z;
	mcnf_pkg::val_t flux_elec_x;
	mcnf_pkg::val_t flux_elec_y;
	mcnf_pkg::val_t flux_elec_z;
	mcnf_pkg::val_t flux_psi;
	mcnf_pkg::val_t flux_phi;
	logic           saturated;
	modport source (output valid, output flux_mag_x, output flux_mag_y, output flux_mag_z,
		output flux_elec_x, output flux_elec_y, output flux_elec_z, output flux_psi,
		output flux_phi, output saturated, input ready);
	modport sink (input valid, input flux_mag_x, input flux_mag_y, input flux_mag_z,
		input flux_elec_x, input flux_elec_y, input flux_elec_z, input flux_psi,
		input flux_phi, input saturated, output ready);
endinterface

@@ rtl/core/mcnf_coef.sv @@
// Configuration registers and the two-stage coefficient unit.
`timescale 1ns / 1ps
`include "maxwell_cleaning_normal_flux_macros.svh"

module mcnf_coef (
	input  logic                clk,
	input  logic                arst_n,
	mcnf_cfg_if.sink            cfg,
	output logic                busy,
	output mcnf_pkg::coef_set_t coefs
);

	localparam int unsigned PW = 2 * mcnf_pkg::COEF_W;
	localparam logic [PW:0] COEF_HALF = (PW + 1)'(1) << (mcnf_pkg::FRAC - 1);
	localparam logic [1:0]  SETTLE_CYCLES = 2'd2;

	mcnf_pkg::coef_t light_speed_q, e_cleaning_q, b_cleaning_q;
	mcnf_pkg::coef_t c2_q, g2_q, x2_q, cx_q;
	logic            sat_a_q, sat_q;
	logic [1:0]      settle_q;

	logic [mcnf_pkg::COEF_W:0] c2_r, g2_r, x2_r, cx_r;

	// Round half up to Q15.16 and clip; the top bit flags the clip.
	function automatic logic [mcnf_pkg::COEF_W:0] coef_round(input logic [PW-1:0] p);
		logic [PW:0]                  t;
		logic [PW-mcnf_pkg::FRAC:0]   r;
		t = {1'b0, p} + COEF_HALF;
		r = t[PW:mcnf_pkg::FRAC];
		if (r[PW-mcnf_pkg::FRAC:mcnf_pkg::COEF_W] != '0)
			return {1'b1, mcnf_pkg::COEF_MAX};
		return {1'b0, r[mcnf_pkg::COEF_W-1:0]};
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_speed_q <= mcnf_pkg::COEF_RESET;
			e_cleaning_q  <= mcnf_pkg::COEF_RESET;
			b_cleaning_q  <= mcnf_pkg::COEF_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				mcnf_pkg::REG_LIGHT_SPEED: light_speed_q <= cfg.data;
				mcnf_pkg::REG_E_CLEANING:  e_cleaning_q  <= cfg.data;
				mcnf_pkg::REG_B_CLEANING:  b_cleaning_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		c2_r = coef_round(PW'(light_speed_q) * PW'(light_speed_q));
		g2_r = coef_round(PW'(b_cleaning_q) * PW'(b_cleaning_q));
		x2_r = coef_round(PW'(e_cleaning_q) * PW'(e_cleaning_q));
		cx_r = coef_round(PW'(c2_q) * PW'(x2_q));
	end

	// Squares in the first stage, the product of squares in the second.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c2_q     <= mcnf_pkg::COEF_RESET;
			g2_q     <= mcnf_pkg::COEF_RESET;
			x2_q     <= mcnf_pkg::COEF_RESET;
			cx_q     <= mcnf_pkg::COEF_RESET;
			sat_a_q  <= 1'b0;
			sat_q    <= 1'b0;
			settle_q <= '0;
		end else begin
			c2_q    <= c2_r[mcnf_pkg::COEF_W-1:0];
			g2_q    <= g2_r[mcnf_pkg::COEF_W-1:0];
			x2_q    <= x2_r[mcnf_pkg::COEF_W-1:0];
			sat_a_q <= c2_r[mcnf_pkg::COEF_W] | g2_r[mcnf_pkg::COEF_W] | x2_r[mcnf_pkg::COEF_W];
			cx_q    <= cx_r[mcnf_pkg::COEF_W-1:0];
			sat_q   <= sat_a_q | cx_r[mcnf_pkg::COEF_W];
			if (cfg.valid && cfg.ready)
				settle_q <= SETTLE_CYCLES;
			else if (settle_q != '0)
				settle_q <= settle_q - 2'd1;
		end
	end

	assign busy  = (settle_q != '0);
	assign coefs = '{c2: c2_q, g2: g2_q, cx: cx_q, sat: sat_q};

	`MCNF_ASSERT_NEXT(a_write_holds_off, clk, arst_n, cfg.valid && cfg.ready, busy)
	`MCNF_ASSERT_SAME(a_zero_speed_zero_c2, clk, arst_n, !busy && light_speed_q == '0, c2_q == '0)

endmodule

@@ rtl/core/mcnf_scale.sv @@
// Pipeline stages one and two: coefficient products and their rounding.
`timescale 1ns / 1ps

module mcnf_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcnf_pkg::face_t     in_data,
	input  mcnf_pkg::coef_set_t coefs,
	output logic                out_valid,
	input  logic                out_ready,
	output mcnf_pkg::scaled_t   out_data
);

	localparam logic signed [mcnf_pkg::ACC_W-1:0] PROD_HALF =
		mcnf_pkg::ACC_W'(1) << (mcnf_pkg::FRAC - 1);

	typedef logic signed [mcnf_pkg::PROD_W-1:0] prod_t;

	prod_t            p_s1, q_s1, bx_s1, by_s1, bz_s1;
	mcnf_pkg::val_t   ex_s1, ey_s1, ez_s1;
	mcnf_pkg::nrm_t   nx_s1, ny_s1, nz_s1;
	logic             csat_s1, v_s1;
	mcnf_pkg::scaled_t data_s2;
	logic             v_s2;
	logic             rdy_s1, rdy_s2;

	function automatic prod_t coef_mul(input mcnf_pkg::coef_t c, input mcnf_pkg::val_t v);
		return $signed({1'b0, c}) * v;
	endfunction

	// Round half up by sixteen bits; the result always fits the scaled width.
	function automatic mcnf_pkg::scl_t round_q16(input prod_t p);
		logic signed [mcnf_pkg::ACC_W-1:0] t;
		t = mcnf_pkg::ACC_W'(p) + PROD_HALF;
		return t[mcnf_pkg::FRAC+mcnf_pkg::SCL_W-1:mcnf_pkg::FRAC];
	endfunction

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= in_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			p_s1    <= coef_mul(coefs.g2, in_data.psi_potential);
			q_s1    <= coef_mul(coefs.cx, in_data.phi_potential);
			bx_s1   <= coef_mul(coefs.c2, in_data.magnetic_x);
			by_s1   <= coef_mul(coefs.c2, in_data.magnetic_y);
			bz_s1   <= coef_mul(coefs.c2, in_data.magnetic_z);
			ex_s1   <= in_data.electric_x;
			ey_s1   <= in_data.electric_y;
			ez_s1   <= in_data.electric_z;
			nx_s1   <= in_data.normal_x;
			ny_s1   <= in_data.normal_y;
			nz_s1   <= in_data.normal_z;
			csat_s1 <= coefs.sat;
		end
		if (rdy_s2 && v_s1) begin
			data_s2.p    <= round_q16(p_s1);
			data_s2.q    <= round_q16(q_s1);
			data_s2.sbx  <= round_q16(bx_s1);
			data_s2.sby  <= round_q16(by_s1);
			data_s2.sbz  <= round_q16(bz_s1);
			data_s2.ex   <= mcnf_pkg::SCL_W'(ex_s1);
			data_s2.ey   <= mcnf_pkg::SCL_W'(ey_s1);
			data_s2.ez   <= mcnf_pkg::SCL_W'(ez_s1);
			data_s2.nx   <= nx_s1;
			data_s2.ny   <= ny_s1;
			data_s2.nz   <= nz_s1;
			data_s2.csat <= csat_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

@@ rtl/core/mcnf_flux.sv @@
// Pipeline stages three to five: normal products, sums, rounding and clipping.
`timescale 1ns / 1ps
`include "maxwell_cleaning_normal_flux_macros.svh"

module mcnf_flux (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mcnf_pkg::scaled_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output mcnf_pkg::result_t out_data
);

	localparam int unsigned NT = 3;
	localparam int unsigned RW = mcnf_pkg::ACC_W - mcnf_pkg::NFRAC;
	localparam logic signed [mcnf_pkg::ACC_W-1:0] ACC_HALF =
		mcnf_pkg::ACC_W'(1) << (mcnf_pkg::NFRAC - 1);
	localparam mcnf_pkg::val_t VAL_MAX = {1'b0, {(mcnf_pkg::VAL_W-1){1'b1}}};
	localparam mcnf_pkg::val_t VAL_MIN = {1'b1, {(mcnf_pkg::VAL_W-1){1'b0}}};

	typedef logic signed [mcnf_pkg::TERM_W-1:0] term_t;
	typedef logic signed [mcnf_pkg::ACC_W-1:0]  acc_t;

	mcnf_pkg::scl_t opd  [mcnf_pkg::NUM_FLUX][NT];
	mcnf_pkg::nrm_t nsel [mcnf_pkg::NUM_FLUX][NT];
	term_t          term_s3 [mcnf_pkg::NUM_FLUX][NT];
	acc_t           acc_s4  [mcnf_pkg::NUM_FLUX];
	mcnf_pkg::val_t flux_s5 [mcnf_pkg::NUM_FLUX];
	logic [mcnf_pkg::VAL_W:0] fin [mcnf_pkg::NUM_FLUX];
	logic           csat_s3, csat_s4, sat_s5, any_clip;
	logic           v_s3, v_s4, v_s5;
	logic           rdy_s3, rdy_s4, rdy_s5;

	// Round half up by fourteen bits and clip to 32 bits; top bit flags a clip.
	function automatic logic [mcnf_pkg::VAL_W:0] finish(input acc_t a);
		acc_t                 t;
		logic signed [RW-1:0] r;
		t = a + ACC_HALF;
		r = t[mcnf_pkg::ACC_W-1:mcnf_pkg::NFRAC];
		if (r[RW-1:mcnf_pkg::VAL_W-1] == '0 || r[RW-1:mcnf_pkg::VAL_W-1] == '1)
			return {1'b0, r[mcnf_pkg::VAL_W-1:0]};
		return {1'b1, (r[RW-1] ? VAL_MIN : VAL_MAX)};
	endfunction

	// Operand routing: the first two terms of every row add, the third of
	// the curl rows subtracts.
	always_comb begin
		opd[mcnf_pkg::F_MAG_X]  = '{in_data.p,   in_data.ez,  in_data.ey};
		nsel[mcnf_pkg::F_MAG_X] = '{in_data.nx,  in_data.ny,  in_data.nz};
		opd[mcnf_pkg::F_MAG_Y]  = '{in_data.p,   in_data.ex,  in_data.ez};
		nsel[mcnf_pkg::F_MAG_Y] = '{in_data.ny,  in_data.nz,  in_data.nx};
		opd[mcnf_pkg::F_MAG_Z]  = '{in_data.p,   in_data.ey,  in_data.ex};
		nsel[mcnf_pkg::F_MAG_Z] = '{in_data.nz,  in_data.nx,  in_data.ny};
		opd[mcnf_pkg::F_ELEC_X] = '{in_data.q,   in_data.sby, in_data.sbz};
		nsel[mcnf_pkg::F_ELEC_X] = '{in_data.nx, in_data.nz,  in_data.ny};
		opd[mcnf_pkg::F_ELEC_Y] = '{in_data.q,   in_data.sbz, in_data.sbx};
		nsel[mcnf_pkg::F_ELEC_Y] = '{in_data.ny, in_data.nx,  in_data.nz};
		opd[mcnf_pkg::F_ELEC_Z] = '{in_data.q,   in_data.sbx, in_data.sby};
		nsel[mcnf_pkg::F_ELEC_Z] = '{in_data.nz, in_data.ny,  in_data.nx};
		opd[mcnf_pkg::F_PSI]    = '{in_data.sbx, in_data.sby, in_data.sbz};
		nsel[mcnf_pkg::F_PSI]   = '{in_data.nx,  in_data.ny,  in_data.nz};
		opd[mcnf_pkg::F_PHI]    = '{in_data.ex,  in_data.ey,  in_data.ez};
		nsel[mcnf_pkg::F_PHI]   = '{in_data.nx,  in_data.ny,  in_data.nz};
	end

	always_comb begin
		any_clip = 1'b0;
		for (int k = 0; k < mcnf_pkg::NUM_FLUX; k++) begin
			fin[k]   = finish(acc_s4[k]);
			any_clip = any_clip | fin[k][mcnf_pkg::VAL_W];
		end
	end

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= in_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
			if (rdy_s5)
				v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			for (int k = 0; k < mcnf_pkg::NUM_FLUX; k++)
				for (int j = 0; j < NT; j++)
					term_s3[k][j] <= opd[k][j] * nsel[k][j];
			csat_s3 <= in_data.csat;
		end
		if (rdy_s4 && v_s3) begin
			for (int k = 0; k < mcnf_pkg::NUM_FLUX; k++) begin
				if (k < mcnf_pkg::NUM_DIFF)
					acc_s4[k] <= mcnf_pkg::ACC_W'(term_s3[k][0])
						+ mcnf_pkg::ACC_W'(term_s3[k][1]) - mcnf_pkg::ACC_W'(term_s3[k][2]);
				else
					acc_s4[k] <= mcnf_pkg::ACC_W'(term_s3[k][0])
						+ mcnf_pkg::ACC_W'(term_s3[k][1]) + mcnf_pkg::ACC_W'(term_s3[k][2]);
			end
			csat_s4 <= csat_s3;
		end
		if (rdy_s5 && v_s4) begin
			for (int k = 0; k < mcnf_pkg::NUM_FLUX; k++)
				flux_s5[k] <= fin[k][mcnf_pkg::VAL_W-1:0];
			sat_s5 <= csat_s4 | any_clip;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = '{
		flux_mag_x:  flux_s5[mcnf_pkg::F_MAG_X],
		flux_mag_y:  flux_s5[mcnf_pkg::F_MAG_Y],
		flux_mag_z:  flux_s5[mcnf_pkg::F_MAG_Z],
		flux_elec_x: flux_s5[mcnf_pkg::F_ELEC_X],
		flux_elec_y: flux_s5[mcnf_pkg::F_ELEC_Y],
		flux_elec_z: flux_s5[mcnf_pkg::F_ELEC_Z],
		flux_psi:    flux_s5[mcnf_pkg::F_PSI],
		flux_phi:    flux_s5[mcnf_pkg::F_PHI],
		saturated:   sat_s5
	};

	`MCNF_ASSERT_NEXT(a_s4_holds, clk, arst_n, v_s4 && !rdy_s5, v_s4 && $stable(acc_s4[0]))
	`MCNF_ASSERT_NEXT(a_s3_moves, clk, arst_n, v_s3 && rdy_s4, v_s4)

endmodule

@@ rtl/core/maxwell_cleaning_normal_flux.sv @@
// Top level of the Maxwell divergence cleaning normal flux pipeline.
`timescale 1ns / 1ps
// Usage notes.
// The block turns one face request on the face channel (B, E, the two
// cleaning potentials and a Q1.14 normal) into one flux request on the flux
// channel: the eight normal flux components in Q16.16 plus a flag that is set
// when any component or coefficient had to be clipped.
// The cfg channel writes the speed of light and the two cleaning factors;
// index 0 is the light speed, 1 the electric and 2 the magnetic factor, and
// other indices are ignored. The cfg channel is always ready.
// Throughput is one face per cycle while face ready is high. The accepting edge
// loads the first of five register stages (coefficient product, rounding,
// normal products, sums, clipping), and the last of them shows the result.
// After a configuration write the face channel is held not ready while the
// two multiplier stages of the coefficient unit refresh c squared, gamma
// squared and c squared chi squared.
// Reset returns all three registers to 1.0 and empties the pipeline; the
// coefficients are valid straight out of reset.
// When the receiver stalls, the output register holds its request and the
// stages behind it keep moving until they fill, so bubbles are squeezed out
// before face ready drops; nothing is lost or repeated.

module maxwell_cleaning_normal_flux (
	input  logic         clk,
	input  logic         arst_n,
	mcnf_cfg_if.sink     cfg,
	mcnf_face_if.sink    face,
	mcnf_flux_if.source  flux
);

	logic                busy;
	mcnf_pkg::coef_set_t coefs;
	mcnf_pkg::face_t     face_data;
	logic                scale_ready;
	logic                scaled_valid, scaled_ready;
	mcnf_pkg::scaled_t   scaled_data;
	mcnf_pkg::result_t   result;

	// Configuration registers and the derived coefficients.
	mcnf_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.busy   (busy),
		.coefs  (coefs)
	);

	assign face_data = '{
		magnetic_x:    face.magnetic_x,
		magnetic_y:    face.magnetic_y,
		magnetic_z:    face.magnetic_z,
		electric_x:    face.electric_x,
		electric_y:    face.electric_y,
		electric_z:    face.electric_z,
		psi_potential: face.psi_potential,
		phi_potential: face.phi_potential,
		normal_x:      face.normal_x,
		normal_y:      face.normal_y,
		normal_z:      face.normal_z
	};

	// Faces are only taken while the coefficients are settled.
	assign face.ready = scale_ready && !busy;

	// Stages one and two scale the potentials and B by their coefficients.
	mcnf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (face.valid && !busy),
		.in_ready  (scale_ready),
		.in_data   (face_data),
		.coefs     (coefs),
		.out_valid (scaled_valid),
		.out_ready (scaled_ready),
		.out_data  (scaled_data)
	);

	// Stages three to five form the products with the normal, sum them and
	// round and clip; stage five is the output register.
	mcnf_flux u_flux (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scaled_valid),
		.in_ready  (scaled_ready),
		.in_data   (scaled_data),
		.out_valid (flux.valid),
		.out_ready (flux.ready),
		.out_data  (result)
	);

	assign flux.flux_mag_x  = result.flux_mag_x;
	assign flux.flux_mag_y  = result.flux_mag_y;
	assign flux.flux_mag_z  = result.flux_mag_z;
	assign flux.flux_elec_x = result.flux_elec_x;
	assign flux.flux_elec_y = result.flux_elec_y;
	assign flux.flux_elec_z = result.flux_elec_z;
	assign flux.flux_psi    = result.flux_psi;
	assign flux.flux_phi    = result.flux_phi;
	assign flux.saturated   = result.saturated;

endmodule
